### sv/dtc_pkg.sv
// shared types, constants and helpers of the thermocouple conditioner
`timescale 1ns / 1ps
package dtc_pkg;

    // digit-serial multiplier geometry
    localparam int MAC_AW = 18;                 // signed multiplicand width
    localparam int MAC_DW = 4;                  // multiplier digit width
    localparam int MAC_ND = 5;                  // digits per multiplier
    localparam int MAC_BW = MAC_DW * MAC_ND;    // multiplier width
    localparam int MAC_PW = MAC_AW + MAC_BW;    // product width

    localparam int SAMPLE_W = 11;
    localparam int GAIN_W   = 16;
    localparam int OFFS_W   = 10;
    localparam int WGHT_W   = 17;
    localparam int TEMP_W   = 16;
    localparam int CIDX_W   = 3;
    localparam int CDAT_W   = 17;
    localparam int CONV_W   = SAMPLE_W + GAIN_W;

    localparam logic signed [OFFS_W-1:0] OFFSET_LIMIT = 10'sd320;
    localparam logic [WGHT_W-1:0]        WEIGHT_ONE   = 17'd65536;

    localparam logic [GAIN_W-1:0]        GAIN_RST   = 16'd26214;
    localparam logic [WGHT_W-1:0]        WEIGHT_RST = 17'd6554;

    typedef enum logic [CIDX_W-1:0] {
        CFG_GAIN   = 3'd0,
        CFG_OFFS1  = 3'd1,
        CFG_OFFS2  = 3'd2,
        CFG_WEIGHT = 3'd3,
        CFG_THRESH = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic        [GAIN_W-1:0] gain;
        logic signed [OFFS_W-1:0] offs1;
        logic signed [OFFS_W-1:0] offs2;
        logic        [WGHT_W-1:0] weight;
        logic signed [TEMP_W-1:0] thresh;
    } t_cfg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CONV,
        S_FILT,
        S_EMA,
        S_DONE
    } t_state;

    // datapath controls decoded from the sequencer state
    typedef struct packed {
        logic in_ready;
        logic mac_load;
        logic mac_ema;
        logic u_we;
        logic f_load_u;
        logic f_load_ema;
        logic out_we;
    } t_ctrl;

    function automatic logic signed [TEMP_W-1:0] sat16(input logic signed [23:0] x);
        logic signed [TEMP_W-1:0] r;
        if (x > 24'sd32767) begin
            r = 16'sh7fff;
        end else if (x < -24'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = x[TEMP_W-1:0];
        end
        return r;
    endfunction

endpackage

### sv/dual_thermocouple_ema_conditioner.sv
// top level: sequencer and datapath of the dual thermocouple filter
//
// Input channel (i_in_valid / o_in_ready) takes one pair of ADC counts.
// Output channel (o_out_valid / i_out_ready) gives both filtered
// temperatures, their mean and spread, and one fault flag per channel.
// Configuration channel (i_cfg_valid / o_cfg_ready) writes one register
// per transfer and is always ready; writes to unknown indexes are dropped.
// Each channel is scaled by conversion_gain and filtered by
// smoothing_weight on two digit-serial multipliers, one per channel, each
// taking five 4-bit digit steps per product. A pair needs one product for
// the conversion and one for the filter update; the first pair after
// reset loads the filters directly and needs only the conversion. A new
// pair is taken only once the previous one has reached the output
// register. Results sit in an output register: the next pair is taken
// while a result still waits, and a stalled receiver holds the block in
// its final step until the register frees. Reset restores the register
// defaults, clears the filters and marks the next pair as the first.
`timescale 1ns / 1ps
module dual_thermocouple_ema_conditioner #(
    parameter int SAMPLE_BITS = 12
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [dtc_pkg::CIDX_W-1:0]          i_cfg_index,
    input  logic [dtc_pkg::CDAT_W-1:0]          i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [dtc_pkg::SAMPLE_W-1:0]        i_sample_one,
    input  logic [dtc_pkg::SAMPLE_W-1:0]        i_sample_two,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic signed [dtc_pkg::TEMP_W-1:0]   o_temp_one,
    output logic signed [dtc_pkg::TEMP_W-1:0]   o_temp_two,
    output logic signed [dtc_pkg::TEMP_W-1:0]   o_temp_mean,
    output logic        [dtc_pkg::TEMP_W-1:0]   o_temp_spread,
    output logic                                o_fault_one,
    output logic                                o_fault_two
);

    localparam int QW = dtc_pkg::CONV_W - SAMPLE_BITS;
    localparam int TW = QW + 2;
    localparam int FW = dtc_pkg::MAC_PW - 16;

    dtc_pkg::t_cfg   w_cfg;
    dtc_pkg::t_state r_state;
    dtc_pkg::t_state n_state;
    dtc_pkg::t_ctrl  w_ctrl;

    logic w_busy1, w_busy2, w_busy;
    logic w_out_free;

    logic signed [dtc_pkg::MAC_AW-1:0] w_a1, w_a2;
    logic        [dtc_pkg::MAC_BW-1:0] w_b;
    logic signed [dtc_pkg::MAC_PW-1:0] w_p1, w_p2;

    logic signed [dtc_pkg::TEMP_W-1:0] r_u1, r_u2, r_f1, r_f2;
    logic signed [dtc_pkg::TEMP_W-1:0] n_u1, n_u2, n_f1, n_f2;
    logic                              r_flt1, r_flt2, r_first;
    logic signed [TW-1:0]              w_t1, w_t2;
    logic signed [FW:0]                w_e1, w_e2;
    logic signed [dtc_pkg::TEMP_W:0]   w_sum, w_diff;
    logic        [dtc_pkg::TEMP_W:0]   w_abs;

    dtc_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_valid),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (w_cfg)
    );

    assign o_cfg_ready = 1'b1;

    // multiplier operands: count by gain, then filter error by weight
    always_comb begin
        if (w_ctrl.mac_ema) begin
            w_a1 = dtc_pkg::MAC_AW'(r_u1) - dtc_pkg::MAC_AW'(r_f1);
            w_a2 = dtc_pkg::MAC_AW'(r_u2) - dtc_pkg::MAC_AW'(r_f2);
            w_b  = dtc_pkg::MAC_BW'(w_cfg.weight);
        end else begin
            w_a1 = $signed({{(dtc_pkg::MAC_AW-dtc_pkg::SAMPLE_W){1'b0}}, i_sample_one});
            w_a2 = $signed({{(dtc_pkg::MAC_AW-dtc_pkg::SAMPLE_W){1'b0}}, i_sample_two});
            w_b  = dtc_pkg::MAC_BW'(w_cfg.gain);
        end
    end

    dtc_dmac u_mac1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_ctrl.mac_load),
        .i_a     (w_a1),
        .i_b     (w_b),
        .o_busy  (w_busy1),
        .o_prod  (w_p1)
    );

    dtc_dmac u_mac2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_ctrl.mac_load),
        .i_a     (w_a2),
        .i_b     (w_b),
        .o_busy  (w_busy2),
        .o_prod  (w_p2)
    );

    assign w_busy     = w_busy1 | w_busy2;
    assign w_out_free = !o_out_valid || i_out_ready;

    // unfiltered temperature: scaled count plus offset
    always_comb begin
        w_t1 = $signed({1'b0, w_p1[dtc_pkg::CONV_W-1:SAMPLE_BITS]}) + TW'(w_cfg.offs1);
        w_t2 = $signed({1'b0, w_p2[dtc_pkg::CONV_W-1:SAMPLE_BITS]}) + TW'(w_cfg.offs2);
        n_u1 = dtc_pkg::sat16(24'(w_t1));
        n_u2 = dtc_pkg::sat16(24'(w_t2));
    end

    // filter step: f + round(w * (u - f) / 65536), ties upward
    always_comb begin
        w_e1 = (FW+1)'(r_f1) + (FW+1)'($signed(w_p1[dtc_pkg::MAC_PW-1:16]))
             + $signed({{FW{1'b0}}, w_p1[15]});
        w_e2 = (FW+1)'(r_f2) + (FW+1)'($signed(w_p2[dtc_pkg::MAC_PW-1:16]))
             + $signed({{FW{1'b0}}, w_p2[15]});
        n_f1 = dtc_pkg::sat16(24'(w_e1));
        n_f2 = dtc_pkg::sat16(24'(w_e2));
    end

    always_comb begin
        w_sum  = (dtc_pkg::TEMP_W+1)'(r_f1) + (dtc_pkg::TEMP_W+1)'(r_f2);
        w_diff = (dtc_pkg::TEMP_W+1)'(r_f1) - (dtc_pkg::TEMP_W+1)'(r_f2);
        w_abs  = w_diff[dtc_pkg::TEMP_W] ? unsigned'(-w_diff) : unsigned'(w_diff);
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            dtc_pkg::S_IDLE: if (i_in_valid) n_state = dtc_pkg::S_CONV;
            dtc_pkg::S_CONV: if (!w_busy) n_state = dtc_pkg::S_FILT;
            dtc_pkg::S_FILT: n_state = r_first ? dtc_pkg::S_DONE : dtc_pkg::S_EMA;
            dtc_pkg::S_EMA:  if (!w_busy) n_state = dtc_pkg::S_DONE;
            dtc_pkg::S_DONE: if (w_out_free) n_state = dtc_pkg::S_IDLE;
            default:         n_state = dtc_pkg::S_IDLE;
        endcase
    end

    // datapath controls
    always_comb begin
        w_ctrl = '0;
        unique case (r_state)
            dtc_pkg::S_IDLE: begin
                w_ctrl.in_ready = 1'b1;
                w_ctrl.mac_load = i_in_valid;
            end
            dtc_pkg::S_CONV: w_ctrl.u_we = !w_busy;
            dtc_pkg::S_FILT: begin
                w_ctrl.f_load_u = r_first;
                w_ctrl.mac_load = !r_first;
                w_ctrl.mac_ema  = 1'b1;
            end
            dtc_pkg::S_EMA:  w_ctrl.f_load_ema = !w_busy;
            dtc_pkg::S_DONE: w_ctrl.out_we = w_out_free;
            default:         w_ctrl = '0;
        endcase
    end

    assign o_in_ready = w_ctrl.in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= dtc_pkg::S_IDLE;
            r_first     <= 1'b1;
            r_f1        <= '0;
            r_f2        <= '0;
            o_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_ctrl.f_load_u) begin
                r_f1    <= r_u1;
                r_f2    <= r_u2;
                r_first <= 1'b0;
            end else if (w_ctrl.f_load_ema) begin
                r_f1 <= n_f1;
                r_f2 <= n_f2;
            end
            if (w_ctrl.out_we) begin
                o_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                o_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctrl.u_we) begin
            r_u1   <= n_u1;
            r_u2   <= n_u2;
            r_flt1 <= n_u1 < w_cfg.thresh;
            r_flt2 <= n_u2 < w_cfg.thresh;
        end
        if (w_ctrl.out_we) begin
            o_temp_one    <= r_f1;
            o_temp_two    <= r_f2;
            o_temp_mean   <= w_sum[dtc_pkg::TEMP_W:1];
            o_temp_spread <= w_abs[dtc_pkg::TEMP_W-1:0];
            o_fault_one   <= r_flt1;
            o_fault_two   <= r_flt2;
        end
    end

    // a result is never shown before the first pair has loaded the filters
    a_first_loaded : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !r_first)
        else $error("result valid while filters still unloaded");

    // both channel multipliers run in lockstep
    a_mac_lockstep : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_busy1 == w_busy2)
        else $error("channel multipliers out of step");

    // a waiting result is not overwritten
    a_hold_result : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_temp_one) && $stable(o_temp_mean))
        else $error("stalled result changed");

    // the delivered temperature is the filter state at load time
    a_result_matches : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctrl.out_we |=> o_out_valid && o_temp_one == $past(r_f1)
                          && o_temp_two == $past(r_f2))
        else $error("result does not match filter state");

    // no multiplier load while a product is still being formed
    a_no_reload : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_busy |-> !w_ctrl.mac_load)
        else $error("multiplier reloaded while busy");

endmodule

### sv/dtc_cfg.sv
// configuration registers with offset and weight clamping
`timescale 1ns / 1ps
module dtc_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_we,
    input  logic [dtc_pkg::CIDX_W-1:0]    i_index,
    input  logic [dtc_pkg::CDAT_W-1:0]    i_data,
    output dtc_pkg::t_cfg                 o_cfg
);

    dtc_pkg::t_cfg r_cfg;
    dtc_pkg::t_cfg n_cfg;

    logic signed [dtc_pkg::OFFS_W-1:0] w_offs_raw;
    logic signed [dtc_pkg::OFFS_W-1:0] w_offs_clamped;
    logic        [dtc_pkg::WGHT_W-1:0] w_weight;

    always_comb begin
        w_offs_raw = $signed(i_data[dtc_pkg::OFFS_W-1:0]);
        if (w_offs_raw > dtc_pkg::OFFSET_LIMIT) begin
            w_offs_clamped = dtc_pkg::OFFSET_LIMIT;
        end else if (w_offs_raw < -dtc_pkg::OFFSET_LIMIT) begin
            w_offs_clamped = -dtc_pkg::OFFSET_LIMIT;
        end else begin
            w_offs_clamped = w_offs_raw;
        end
        w_weight = (i_data > dtc_pkg::WEIGHT_ONE) ? dtc_pkg::WEIGHT_ONE : i_data;
    end

    always_comb begin
        n_cfg = r_cfg;
        if (i_we) begin
            unique case (dtc_pkg::t_cfg_idx'(i_index))
                dtc_pkg::CFG_GAIN:   n_cfg.gain   = i_data[dtc_pkg::GAIN_W-1:0];
                dtc_pkg::CFG_OFFS1:  n_cfg.offs1  = w_offs_clamped;
                dtc_pkg::CFG_OFFS2:  n_cfg.offs2  = w_offs_clamped;
                dtc_pkg::CFG_WEIGHT: n_cfg.weight = w_weight;
                dtc_pkg::CFG_THRESH: n_cfg.thresh = $signed(i_data[dtc_pkg::TEMP_W-1:0]);
                default:             n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gain   <= dtc_pkg::GAIN_RST;
            r_cfg.offs1  <= '0;
            r_cfg.offs2  <= '0;
            r_cfg.weight <= dtc_pkg::WEIGHT_RST;
            r_cfg.thresh <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

### sv/dtc_dmac.sv
// digit-serial signed by unsigned multiplier, one 4-bit digit per cycle
`timescale 1ns / 1ps
module dtc_dmac (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_load,
    input  logic signed [dtc_pkg::MAC_AW-1:0]    i_a,
    input  logic        [dtc_pkg::MAC_BW-1:0]    i_b,
    output logic                                 o_busy,
    output logic signed [dtc_pkg::MAC_PW-1:0]    o_prod
);

    localparam int SW = dtc_pkg::MAC_AW + dtc_pkg::MAC_DW + 1;
    localparam int CW = $clog2(dtc_pkg::MAC_ND + 1);

    logic signed [dtc_pkg::MAC_AW-1:0] r_a;
    logic        [dtc_pkg::MAC_BW-1:0] r_b;
    logic signed [dtc_pkg::MAC_AW-1:0] r_acc;
    logic        [dtc_pkg::MAC_BW-1:0] r_lo;
    logic        [CW-1:0]              r_cnt;
    logic                              r_busy;

    logic signed [SW-1:0] w_pp;
    logic signed [SW-1:0] w_sum;

    // partial product of the multiplicand and the lowest remaining digit
    always_comb begin
        w_pp  = SW'(r_a) * $signed({1'b0, r_b[dtc_pkg::MAC_DW-1:0]});
        w_sum = SW'(r_acc) + w_pp;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_load) begin
            r_busy <= 1'b1;
            r_cnt  <= CW'(dtc_pkg::MAC_ND);
        end else if (r_busy) begin
            r_cnt  <= r_cnt - 1'b1;
            r_busy <= (r_cnt != CW'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_a   <= i_a;
            r_b   <= i_b;
            r_acc <= '0;
            r_lo  <= '0;
        end else if (r_busy) begin
            // low digit of the running sum drops into the product's low half
            r_acc <= w_sum[dtc_pkg::MAC_AW+dtc_pkg::MAC_DW-1:dtc_pkg::MAC_DW];
            r_lo  <= {w_sum[dtc_pkg::MAC_DW-1:0], r_lo[dtc_pkg::MAC_BW-1:dtc_pkg::MAC_DW]};
            r_b   <= r_b >> dtc_pkg::MAC_DW;
        end
    end

    assign o_busy = r_busy;
    assign o_prod = {r_acc, r_lo};

endmodule

### tb/testbench.sv
// self-checking testbench of the dual thermocouple filter with its own behavioural predictor
`timescale 1ns / 1ps
module testbench;
    import dtc_pkg::*;

    localparam int SAMPLE_BITS     = 12;
    localparam int RESET_CYCLES    = 11;
    localparam int SETTLE_CYCLES   = 40;
    localparam int TAIL_CYCLES     = 60;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int RANDOM_PHASES   = 8;
    localparam int PAIRS_PER_PHASE = 150;
    localparam int HOLD_PHASE      = 2;
    localparam int HOLD_CYCLES     = 400;
    localparam int GAP_MAX         = 20;
    localparam int STALL_MAX       = 12;
    localparam int WEIGHT_FRAC     = 16;

    localparam longint TEMP_MAX   = 32767;
    localparam longint TEMP_MIN   = -32768;
    localparam longint ROUND_HALF = 32768;

    localparam logic [SAMPLE_W-1:0] COUNT_MAX = '1;

    // indexes outside the register map, writes there must be dropped
    localparam logic [CIDX_W-1:0] CFG_SPARE_FIRST = 3'd5;
    localparam logic [CIDX_W-1:0] CFG_SPARE_MID   = 3'd6;
    localparam logic [CIDX_W-1:0] CFG_SPARE_LAST  = 3'd7;

    // receiver stall patterns
    localparam int RX_STEADY = 0;
    localparam int RX_COIN   = 1;
    localparam int RX_THIRD  = 2;
    localparam int RX_RUNS   = 3;

    typedef struct packed {
        logic [SAMPLE_W-1:0] one;
        logic [SAMPLE_W-1:0] two;
    } t_pair;

    typedef struct packed {
        logic [TEMP_W-1:0] one;
        logic [TEMP_W-1:0] two;
        logic [TEMP_W-1:0] mean;
        logic [TEMP_W-1:0] spread;
        logic              fault_one;
        logic              fault_two;
    } t_reading;

    logic                     i_clk         = 1'b0;
    logic                     i_rst_n       = 1'b0;
    logic                     i_cfg_valid   = 1'b0;
    logic [CIDX_W-1:0]        i_cfg_index   = '0;
    logic [CDAT_W-1:0]        i_cfg_data    = '0;
    logic                     i_in_valid    = 1'b0;
    logic [SAMPLE_W-1:0]      i_sample_one  = '0;
    logic [SAMPLE_W-1:0]      i_sample_two  = '0;
    logic                     i_out_ready   = 1'b0;
    logic                     o_cfg_ready;
    logic                     o_in_ready;
    logic                     o_out_valid;
    logic signed [TEMP_W-1:0] o_temp_one;
    logic signed [TEMP_W-1:0] o_temp_two;
    logic signed [TEMP_W-1:0] o_temp_mean;
    logic        [TEMP_W-1:0] o_temp_spread;
    logic                     o_fault_one;
    logic                     o_fault_two;

    // predictor copy of the registers and the filter state
    logic        [GAIN_W-1:0] gain_q        = GAIN_RST;
    logic signed [OFFS_W-1:0] offset_one_q  = '0;
    logic signed [OFFS_W-1:0] offset_two_q  = '0;
    logic        [WGHT_W-1:0] weight_q      = WEIGHT_RST;
    logic signed [TEMP_W-1:0] threshold_q   = '0;
    logic signed [TEMP_W-1:0] filt_one      = '0;
    logic signed [TEMP_W-1:0] filt_two      = '0;
    logic                     awaiting_first = 1'b1;

    t_pair    pending_pairs[$];
    t_reading expected_readings[$];

    logic in_accepted  = 1'b0;
    logic cfg_accepted = 1'b0;
    int   pairs_queued     = 0;
    int   pairs_accepted   = 0;
    int   readings_checked = 0;
    int   register_writes  = 0;
    int   settings_applied = 0;
    int   mismatches       = 0;
    int   hold_requests    = 0;
    int   holds_done       = 0;
    int   cycle_count      = 0;
    int   gap_left         = 0;
    int   burst_left       = 1;
    int   rx_mode          = RX_STEADY;
    int   mode_left        = 0;
    int   hold_left        = 0;
    int   stall_left       = 0;
    int   rx_tick          = 0;

    dual_thermocouple_ema_conditioner #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_sample_one (i_sample_one),
        .i_sample_two (i_sample_two),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_temp_one   (o_temp_one),
        .o_temp_two   (o_temp_two),
        .o_temp_mean  (o_temp_mean),
        .o_temp_spread(o_temp_spread),
        .o_fault_one  (o_fault_one),
        .o_fault_two  (o_fault_two)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic logic signed [TEMP_W-1:0] limit_to_temp(input longint x);
        if (x > TEMP_MAX) begin
            return TEMP_MAX[TEMP_W-1:0];
        end
        if (x < TEMP_MIN) begin
            return TEMP_MIN[TEMP_W-1:0];
        end
        return x[TEMP_W-1:0];
    endfunction

    function automatic logic signed [OFFS_W-1:0] clamp_offset(input logic signed [OFFS_W-1:0] v);
        if (v > OFFSET_LIMIT) begin
            return OFFSET_LIMIT;
        end
        if (v < -OFFSET_LIMIT) begin
            return -OFFSET_LIMIT;
        end
        return v;
    endfunction

    function automatic void apply_register(input logic [CIDX_W-1:0] idx,
                                           input logic [CDAT_W-1:0] value);
        case (idx)
            CFG_GAIN:   gain_q       = value[GAIN_W-1:0];
            CFG_OFFS1:  offset_one_q = clamp_offset(value[OFFS_W-1:0]);
            CFG_OFFS2:  offset_two_q = clamp_offset(value[OFFS_W-1:0]);
            CFG_WEIGHT: weight_q     = (value > WEIGHT_ONE) ? WEIGHT_ONE : value;
            CFG_THRESH: threshold_q  = value[TEMP_W-1:0];
            default: ;
        endcase
    endfunction

    // unfiltered temperature: floor(count * gain / 2^SAMPLE_BITS) + offset, saturated
    function automatic logic signed [TEMP_W-1:0] count_to_temp(
        input logic [SAMPLE_W-1:0] count, input logic signed [OFFS_W-1:0] offs);
        longint scaled;
        scaled = ((longint'(count) * longint'(gain_q)) >>> SAMPLE_BITS) + longint'(offs);
        return limit_to_temp(scaled);
    endfunction

    // round to nearest, ties towards plus infinity
    function automatic logic signed [TEMP_W-1:0] smooth(input logic signed [TEMP_W-1:0] prev,
                                                        input logic signed [TEMP_W-1:0] fresh);
        longint w;
        longint acc;
        w   = longint'(weight_q);
        acc = w * longint'(fresh) + (longint'(WEIGHT_ONE) - w) * longint'(prev) + ROUND_HALF;
        return limit_to_temp(acc >>> WEIGHT_FRAC);
    endfunction

    function automatic t_reading filter_pair(input logic [SAMPLE_W-1:0] count_one,
                                             input logic [SAMPLE_W-1:0] count_two);
        logic signed [TEMP_W-1:0] raw_one;
        logic signed [TEMP_W-1:0] raw_two;
        longint sum;
        longint diff;
        t_reading r;
        raw_one = count_to_temp(count_one, offset_one_q);
        raw_two = count_to_temp(count_two, offset_two_q);
        if (awaiting_first) begin
            filt_one       = raw_one;
            filt_two       = raw_two;
            awaiting_first = 1'b0;
        end else begin
            filt_one = smooth(filt_one, raw_one);
            filt_two = smooth(filt_two, raw_two);
        end
        sum  = (longint'(filt_one) + longint'(filt_two)) >>> 1;
        diff = longint'(filt_one) - longint'(filt_two);
        if (diff < 0) begin
            diff = -diff;
        end
        r.one       = filt_one;
        r.two       = filt_two;
        r.mean      = sum[TEMP_W-1:0];
        r.spread    = diff[TEMP_W-1:0];
        r.fault_one = raw_one < threshold_q;
        r.fault_two = raw_two < threshold_q;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [TEMP_W-1:0] want,
                               input logic [TEMP_W-1:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0d (0x%h), got %0d (0x%h)",
                     $time, name, want, want, got, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin : monitor
        t_reading want;
        t_reading got;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                apply_register(i_cfg_index, i_cfg_data);
            end
            if (i_in_valid && o_in_ready) begin
                expected_readings.push_back(filter_pair(i_sample_one, i_sample_two));
                pairs_accepted++;
            end
            if (o_out_valid && i_out_ready) begin
                got = {o_temp_one, o_temp_two, o_temp_mean, o_temp_spread,
                       o_fault_one, o_fault_two};
                if (expected_readings.size() == 0) begin
                    $display("%0t: reading with none expected, got 0x%h", $time, got);
                    mismatches++;
                end else begin
                    want = expected_readings.pop_front();
                    check_field("temp_one", want.one, got.one);
                    check_field("temp_two", want.two, got.two);
                    check_field("temp_mean", want.mean, got.mean);
                    check_field("temp_spread", want.spread, got.spread);
                    check_field("fault_one", TEMP_W'(want.fault_one), TEMP_W'(got.fault_one));
                    check_field("fault_two", TEMP_W'(want.fault_two), TEMP_W'(got.fault_two));
                    readings_checked++;
                end
            end
        end
        in_accepted  <= i_rst_n && i_in_valid && o_in_ready;
        cfg_accepted <= i_rst_n && i_cfg_valid && o_cfg_ready;
    end

    // sender: bursts of pairs with random gaps
    always @(negedge i_clk) begin : sender
        t_pair next_pair;
        logic  valid_next;
        if (i_rst_n && (!i_in_valid || in_accepted)) begin
            valid_next = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
            end else if (pending_pairs.size() != 0) begin
                next_pair = pending_pairs.pop_front();
                i_sample_one <= next_pair.one;
                i_sample_two <= next_pair.two;
                valid_next = 1'b1;
                if (burst_left > 1) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(1, 30);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, GAP_MAX);
                end
            end
            i_in_valid <= valid_next;
        end
    end

    // receiver: stall pattern is re-drawn at random, with an optional long hold
    always @(negedge i_clk) begin : receiver
        logic ready_next;
        ready_next = 1'b1;
        rx_tick++;
        if (mode_left == 0) begin
            rx_mode   = $urandom_range(RX_STEADY, RX_RUNS);
            mode_left = $urandom_range(50, 300);
        end else begin
            mode_left--;
        end
        if (holds_done != hold_requests) begin
            hold_left = HOLD_CYCLES;
            holds_done++;
        end
        if (hold_left > 0) begin
            hold_left--;
            ready_next = 1'b0;
        end else begin
            case (rx_mode)
                RX_COIN:  ready_next = $urandom_range(0, 1);
                RX_THIRD: ready_next = (rx_tick % 3) != 0;
                RX_RUNS: begin
                    if (stall_left > 0) begin
                        stall_left--;
                        ready_next = 1'b0;
                    end else if ($urandom_range(0, 5) == 0) begin
                        stall_left = $urandom_range(1, STALL_MAX);
                        ready_next = 1'b0;
                    end
                end
                default: ready_next = 1'b1;
            endcase
        end
        i_out_ready <= ready_next;
    end

    always @(posedge i_clk) begin : watchdog
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: run stopped after %0d cycles, %0d readings outstanding",
                     $time, cycle_count, expected_readings.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic write_register(input logic [CIDX_W-1:0] idx, input logic [CDAT_W-1:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(negedge i_clk); while (!cfg_accepted);
        i_cfg_valid <= 1'b0;
        register_writes++;
    endtask

    task automatic write_all(input logic [CDAT_W-1:0] gain, input logic [CDAT_W-1:0] offs1,
                             input logic [CDAT_W-1:0] offs2, input logic [CDAT_W-1:0] weight,
                             input logic [CDAT_W-1:0] thresh);
        write_register(CFG_GAIN, gain);
        write_register(CFG_OFFS1, offs1);
        write_register(CFG_OFFS2, offs2);
        write_register(CFG_WEIGHT, weight);
        write_register(CFG_THRESH, thresh);
        settings_applied++;
    endtask

    task automatic queue_pair(input logic [SAMPLE_W-1:0] one, input logic [SAMPLE_W-1:0] two);
        pending_pairs.push_back('{one: one, two: two});
        pairs_queued++;
    endtask

    // block is idle once every accepted pair has produced its reading
    task automatic settle();
        while (pairs_accepted != pairs_queued || expected_readings.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    initial begin : stimulus
        logic [GAIN_W-1:0] gain_pick;
        logic [CDAT_W-1:0] weight_word;
        logic [CDAT_W-1:0] thresh_word;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset defaults, the first pair loads the filters directly
        queue_pair(11'd1000, 11'd1000);
        queue_pair('0, COUNT_MAX);
        queue_pair(COUNT_MAX, '0);
        queue_pair(11'h555, 11'h2aa);
        queue_pair(11'h2aa, 11'h555);
        queue_pair(COUNT_MAX, COUNT_MAX);
        queue_pair('0, '0);
        settle();

        // full gain with clamped offsets, weight above one, highest threshold
        write_all(17'h1ffff, 17'h001ff, 17'h00200, 17'h1ffff, 17'h07fff);
        queue_pair(COUNT_MAX, '0);
        queue_pair(COUNT_MAX, COUNT_MAX);
        queue_pair('0, COUNT_MAX);
        queue_pair(11'd1024, 11'd1024);
        settle();

        // zero weight holds the filters, upper data bits ignored, lowest threshold
        write_all(17'h10000, 17'h1fc64, 17'h1ffff, 17'h00000, 17'h18000);
        write_register(CFG_SPARE_FIRST, 17'h1ffff);
        write_register(CFG_SPARE_MID, 17'h00000);
        write_register(CFG_SPARE_LAST, 17'h0aaaa);
        queue_pair(COUNT_MAX, COUNT_MAX);
        queue_pair(11'd5, 11'd1000);
        queue_pair('0, '0);
        settle();

        // unity scale and half weight to hit the rounding ties
        write_all(17'd4096, 17'h002c0, 17'h00140, 17'd32768, 17'h00000);
        queue_pair('0, '0);
        queue_pair(11'd1, 11'd2);
        queue_pair(11'd320, 11'd319);
        queue_pair(COUNT_MAX, 11'd1);
        settle();

        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            case ($urandom_range(0, 4))
                0:       gain_pick = '0;
                1:       gain_pick = '1;
                2:       gain_pick = GAIN_RST;
                default: gain_pick = $urandom;
            endcase
            case ($urandom_range(0, 5))
                0:       weight_word = '0;
                1:       weight_word = WEIGHT_ONE;
                2:       weight_word = $urandom_range(65537, 131071);
                3:       weight_word = $urandom_range(1, 4096);
                default: weight_word = $urandom_range(0, 65536);
            endcase
            // thresholds near the temperatures in play make the fault flags toggle
            if ($urandom_range(0, 1) == 0) begin
                thresh_word = CDAT_W'($urandom);
            end else begin
                thresh_word = CDAT_W'(($urandom_range(0, 2047) * gain_pick) >> SAMPLE_BITS);
            end
            write_all({1'($urandom), gain_pick},
                      {7'($urandom), 10'($urandom_range(0, 640) - 320)},
                      ($urandom_range(0, 3) == 0) ? CDAT_W'($urandom)
                          : {7'($urandom), 10'($urandom_range(0, 640) - 320)},
                      weight_word, thresh_word);
            if ($urandom_range(0, 2) == 0) begin
                write_register(CFG_SPARE_FIRST + CIDX_W'($urandom_range(0, 2)), CDAT_W'($urandom));
            end
            for (int k = 0; k < PAIRS_PER_PHASE; k++) begin
                if ($urandom_range(0, 7) == 0) begin
                    queue_pair($urandom_range(0, 1) ? COUNT_MAX : '0,
                               $urandom_range(0, 1) ? COUNT_MAX : '0);
                end else begin
                    queue_pair(SAMPLE_W'($urandom), SAMPLE_W'($urandom));
                end
            end
            // long receiver hold while the sender keeps offering pairs
            if (phase == HOLD_PHASE) begin
                hold_requests++;
            end
            settle();
        end

        repeat (TAIL_CYCLES) @(negedge i_clk);
        $display("%0d sample pairs sent, %0d filtered readings checked", pairs_queued,
                 readings_checked);
        $display("%0d register transfers over %0d settings, %0d long receiver hold(s)",
                 register_writes, settings_applied, holds_done);
        if (mismatches == 0 && expected_readings.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
